@@ hw/rtl/mbtrf_pkg.sv @@
`default_nettype none
package mbtrf_pkg;

  localparam int MaxWriteWords = 123;

  // Configuration register indexes
  localparam logic [1:0] REG_TRANSACTION_ID = 2'd0;
  localparam logic [1:0] REG_PROTOCOL_ID    = 2'd1;
  localparam logic [1:0] REG_UNIT_ID        = 2'd2;

  // Input item kinds
  localparam logic [2:0] KIND_READ_HOLDING = 3'd0;
  localparam logic [2:0] KIND_READ_INPUT   = 3'd1;
  localparam logic [2:0] KIND_WRITE_SINGLE = 3'd2;
  localparam logic [2:0] KIND_WRITE_MULTI  = 3'd3;
  localparam logic [2:0] KIND_DATA_WORD    = 3'd4;

  // Modbus function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

  // MBAP length of a fixed 12-byte request
  localparam logic [7:0] SHORT_LEN = 8'd6;
  // MBAP length of a write-multiple request, less its data bytes
  localparam logic [7:0] MULTI_LEN_BASE = 8'd7;

  // Last byte index of each command
  localparam logic [3:0] LAST_IDX_REJECT = 4'd0;
  localparam logic [3:0] LAST_IDX_SHORT  = 4'd11;
  localparam logic [3:0] LAST_IDX_MULTI  = 4'd12;
  localparam logic [3:0] LAST_IDX_DATA   = 4'd1;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_SHORT,
    CMD_MULTI,
    CMD_DATA
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] word;
    logic        mark_last;
  } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/mbtrf_front.sv @@
`default_nettype none
module mbtrf_front
  import mbtrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [2:0]  kind,
  input  wire logic [15:0] reg_address,
  input  wire logic [15:0] reg_count,
  input  wire logic [15:0] reg_value,
  output cmd_t             cmd
);

  logic [6:0] words_left;
  logic [6:0] words_left_next;

  always_comb begin
    cmd.op          = CMD_REJECT;
    cmd.fc          = FC_READ_HOLDING;
    cmd.addr        = reg_address;
    cmd.word        = reg_count;
    cmd.mark_last   = 1'b0;
    words_left_next = words_left;
    if (kind == KIND_DATA_WORD) begin
      if (words_left != 7'd0) begin
        cmd.op          = CMD_DATA;
        cmd.word        = reg_value;
        cmd.mark_last   = (words_left == 7'd1);
        words_left_next = words_left - 7'd1;
      end
    end else if (words_left == 7'd0) begin
      case (kind)
        KIND_READ_HOLDING, KIND_READ_INPUT: begin
          if (reg_count != 16'd0) begin
            cmd.op = CMD_SHORT;
            cmd.fc = (kind == KIND_READ_HOLDING) ? FC_READ_HOLDING : FC_READ_INPUT;
          end
        end
        KIND_WRITE_SINGLE: begin
          cmd.op   = CMD_SHORT;
          cmd.fc   = FC_WRITE_SINGLE;
          cmd.word = reg_value;
        end
        KIND_WRITE_MULTI: begin
          if (reg_count != 16'd0 && reg_count <= 16'(MaxWriteWords)) begin
            cmd.op          = CMD_MULTI;
            cmd.fc          = FC_WRITE_MULTI;
            words_left_next = reg_count[6:0];
          end
        end
        default: begin
          cmd.op = CMD_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left <= 7'd0;
    end else if (accept) begin
      words_left <= words_left_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mbtrf_cmd_fifo.sv @@
`default_nettype none
module mbtrf_cmd_fifo
  import mbtrf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      not_empty
);

  // Two-entry queue between classifier and serializer
  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mbtrf_back.sv @@
`default_nettype none
module mbtrf_back
  import mbtrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] transaction_id,
  input  wire logic [15:0] protocol_id,
  input  wire logic [7:0]  unit_id,
  input  wire cmd_t        head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       tx_byte,
  output logic             frame_last,
  output logic             rejected
);

  logic [3:0] idx;
  logic [3:0] last_idx;
  logic       load;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic [7:0] len_lo;
  logic [7:0] len_hi;
  logic [7:0] byte_cnt;

  // Write-multiple word count is at most MaxWriteWords, so 7 bits carry it
  assign byte_cnt = {head.word[6:0], 1'b0};

  always_comb begin
    len_hi = 8'd0;
    len_lo = SHORT_LEN;
    if (head.op == CMD_MULTI) begin
      len_lo = MULTI_LEN_BASE + byte_cnt;
    end
  end

  always_comb begin
    case (head.op)
      CMD_REJECT: last_idx = LAST_IDX_REJECT;
      CMD_SHORT:  last_idx = LAST_IDX_SHORT;
      CMD_MULTI:  last_idx = LAST_IDX_MULTI;
      default:    last_idx = LAST_IDX_DATA;
    endcase
  end

  always_comb begin
    byte_sel = 8'd0;
    last_sel = 1'b0;
    if (head.op == CMD_DATA) begin
      byte_sel = (idx == 4'd0) ? head.word[15:8] : head.word[7:0];
      last_sel = (idx != 4'd0) && head.mark_last;
    end else if (head.op != CMD_REJECT) begin
      case (idx)
        4'd0:    byte_sel = transaction_id[15:8];
        4'd1:    byte_sel = transaction_id[7:0];
        4'd2:    byte_sel = protocol_id[15:8];
        4'd3:    byte_sel = protocol_id[7:0];
        4'd4:    byte_sel = len_hi;
        4'd5:    byte_sel = len_lo;
        4'd6:    byte_sel = unit_id;
        4'd7:    byte_sel = head.fc;
        4'd8:    byte_sel = head.addr[15:8];
        4'd9:    byte_sel = head.addr[7:0];
        4'd10:   byte_sel = head.word[15:8];
        4'd11: begin
          byte_sel = head.word[7:0];
          last_sel = (head.op == CMD_SHORT);
        end
        default: byte_sel = byte_cnt;
      endcase
    end
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= pop ? 4'd0 : idx + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte    <= byte_sel;
      frame_last <= last_sel;
      rejected   <= (head.op == CMD_REJECT);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/modbus_tcp_request_framer_unit.sv @@
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | kind, reg_address, reg_count, reg_value
// out     | output    | out_valid/out_ready | tx_byte, frame_last, rejected
// cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One byte word leaves per cycle, output stalls aside, from a registered output
// stage; the serializer walks a byte index over the queued command: a read or
// single-write frame is 12 bytes, a write-multiple header 13, a data word 2, a reject 1.
// Input words enter back to back while the two-entry command queue has room.
// Synchronous active-high reset empties the queue, drops out_valid, clears the
// open-frame word count and restores the config defaults.
// An output stall backs up into the queue and then drops in_ready.
`default_nettype none
module modbus_tcp_request_framer_unit
  import mbtrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // request input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [15:0] reg_address,
  input  wire logic [15:0] reg_count,
  input  wire logic [15:0] reg_value,
  // frame byte output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       tx_byte,
  output logic             frame_last,
  output logic             rejected
);

  logic [15:0] transaction_id;
  logic [15:0] protocol_id;
  logic [7:0]  unit_id;

  cmd_t front_cmd;
  cmd_t head;
  logic in_accept;
  logic q_full;
  logic q_not_empty;
  logic q_pop;

  // Config registers; the user must write them only while idle (the block does not
  // enforce this), so the serializer reads them live.
  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_id <= 16'd0;
      protocol_id    <= 16'd0;
      unit_id        <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRANSACTION_ID: transaction_id <= cfg_data;
        REG_PROTOCOL_ID:    protocol_id    <= cfg_data;
        REG_UNIT_ID:        unit_id        <= cfg_data[7:0];
        default:            ;
      endcase
    end
  end

  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // Front: classify the request and track words owed to an open frame
  mbtrf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .kind        (kind),
    .reg_address (reg_address),
    .reg_count   (reg_count),
    .reg_value   (reg_value),
    .cmd         (front_cmd)
  );

  // Command queue decouples classification from byte serialization
  mbtrf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back: emit the command one byte per cycle while the output is not stalled
  mbtrf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .transaction_id (transaction_id),
    .protocol_id    (protocol_id),
    .unit_id        (unit_id),
    .head           (head),
    .head_valid     (q_not_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_byte        (tx_byte),
    .frame_last     (frame_last),
    .rejected       (rejected)
  );

endmodule
`default_nettype wire

@@ hw/rtl/mbtrf_checker.sv @@
`default_nettype none
module mbtrf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [15:0] cfg_data,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  kind,
  input wire logic [15:0] reg_address,
  input wire logic [15:0] reg_count,
  input wire logic [15:0] reg_value,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  tx_byte,
  input wire logic        frame_last,
  input wire logic        rejected
);

  // A reject word carries no frame byte and never closes a frame
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> (tx_byte == 8'd0 && !frame_last))
    else $error("reject word carries frame data");

  // Out of reset the queue is empty and nothing is offered
  a_reset_out: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!out_valid && in_ready))
    else $error("not idle after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte)
      && $stable(frame_last) && $stable(rejected)))
    else $error("stalled output word changed");

endmodule

bind modbus_tcp_request_framer_unit mbtrf_checker u_mbtrf_checker (.*);
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import mbtrf_pkg::*;

  // Kinds above the data word are not defined; the last code the field can hold
  localparam logic [2:0] KIND_TOP_CODE = 3'd7;
  // Cycles to let pass once the last expected byte is in (deepest frame is 13)
  localparam int DRAIN_CYCLES = 20;
  // Hard stop on the whole run, far above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  // Length of the long receiver stall in the backpressure test
  localparam int LONG_HOLD_CYCLES = 400;

  // One output word of the framer
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rej;
  } frame_byte_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_index   = REG_TRANSACTION_ID;
  logic [15:0] cfg_data    = 16'h0000;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [2:0]  kind        = KIND_READ_HOLDING;
  logic [15:0] reg_address = 16'h0000;
  logic [15:0] reg_count   = 16'h0000;
  logic [15:0] reg_value   = 16'h0000;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  tx_byte;
  logic        frame_last;
  logic        rejected;

  // Shadow copy of the framer: MBAP config and the open write-multiple frame
  logic [15:0] mbap_trans_id = 16'h0000;
  logic [15:0] mbap_proto_id = 16'h0000;
  logic [7:0]  mbap_unit_id  = 8'h01;
  logic [6:0]  owed_words    = 7'd0;

  // Frame bytes predicted but not yet seen on the output, oldest first
  frame_byte_t frame_bytes_due[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int mismatch_count = 0;

  modbus_tcp_request_framer_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame prediction
  // ---------------------------------------------------------------------------
  function automatic void push_frame_byte(input logic [7:0] data, input logic last,
                                          input logic rej);
    frame_byte_t fb;
    fb.data = data;
    fb.last = last;
    fb.rej  = rej;
    frame_bytes_due.push_back(fb);
  endfunction

  // MBAP header, function code, address and one 16-bit field, all big-endian
  function automatic void push_mbap_request(input logic [15:0] len, input logic [7:0] fc,
                                            input logic [15:0] addr, input logic [15:0] fld,
                                            input logic last_on_fld);
    push_frame_byte(mbap_trans_id[15:8], 1'b0, 1'b0);
    push_frame_byte(mbap_trans_id[7:0], 1'b0, 1'b0);
    push_frame_byte(mbap_proto_id[15:8], 1'b0, 1'b0);
    push_frame_byte(mbap_proto_id[7:0], 1'b0, 1'b0);
    push_frame_byte(len[15:8], 1'b0, 1'b0);
    push_frame_byte(len[7:0], 1'b0, 1'b0);
    push_frame_byte(mbap_unit_id, 1'b0, 1'b0);
    push_frame_byte(fc, 1'b0, 1'b0);
    push_frame_byte(addr[15:8], 1'b0, 1'b0);
    push_frame_byte(addr[7:0], 1'b0, 1'b0);
    push_frame_byte(fld[15:8], 1'b0, 1'b0);
    push_frame_byte(fld[7:0], last_on_fld, 1'b0);
  endfunction

  // Works out the bytes one accepted request word turns into and updates the
  // open-frame count. Any refusal is a single byte 0 with only rejected set.
  function automatic void frame_request(input logic [2:0] k, input logic [15:0] addr,
                                        input logic [15:0] cnt, input logic [15:0] val);
    logic [15:0] multi_len;
    multi_len = {8'h00, MULTI_LEN_BASE} + {cnt[14:0], 1'b0};
    if (k == KIND_DATA_WORD) begin
      if (owed_words == 7'd0) begin
        push_frame_byte(8'h00, 1'b0, 1'b1);     // stray data word
      end else begin
        owed_words = owed_words - 7'd1;
        push_frame_byte(val[15:8], 1'b0, 1'b0);
        push_frame_byte(val[7:0], owed_words == 7'd0, 1'b0);
      end
    end else if (k > KIND_DATA_WORD || owed_words != 7'd0) begin
      // undefined kind, or a header while a write-multiple frame is still open
      push_frame_byte(8'h00, 1'b0, 1'b1);
    end else begin
      case (k)
        KIND_READ_HOLDING, KIND_READ_INPUT: begin
          if (cnt == 16'd0) begin
            push_frame_byte(8'h00, 1'b0, 1'b1);
          end else begin
            // read counts go out as given, no range check
            push_mbap_request({8'h00, SHORT_LEN},
                              (k == KIND_READ_HOLDING) ? FC_READ_HOLDING : FC_READ_INPUT,
                              addr, cnt, 1'b1);
          end
        end
        KIND_WRITE_SINGLE: begin
          push_mbap_request({8'h00, SHORT_LEN}, FC_WRITE_SINGLE, addr, val, 1'b1);
        end
        default: begin
          if (cnt == 16'd0 || cnt > 16'(MaxWriteWords)) begin
            push_frame_byte(8'h00, 1'b0, 1'b1);
          end else begin
            // header and byte count never carry frame_last; the last data word closes it
            push_mbap_request(multi_len, FC_WRITE_MULTI, addr, cnt, 1'b0);
            push_frame_byte({cnt[6:0], 1'b0}, 1'b0, 1'b0);
            owed_words = cnt[6:0];
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one request word and returns at the edge that takes it. in_valid is
  // left high so a following word can go out back to back.
  task automatic send_request(input logic [2:0] k, input logic [15:0] addr,
                              input logic [15:0] cnt, input logic [15:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    reg_address <= addr;
    reg_count   <= cnt;
    reg_value   <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    frame_request(k, addr, cnt, val);
  endtask

  // Drops valid and waits until every predicted byte has come out
  task automatic wait_frames_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three MBAP registers back to back; only called with the block idle
  task automatic set_mbap_config(input logic [15:0] tid, input logic [15:0] pid,
                                 input logic [7:0] uid);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TRANSACTION_ID;
    cfg_data  <= tid;
    @(posedge clk);
    mbap_trans_id = tid;
    cfg_index <= REG_PROTOCOL_ID;
    cfg_data  <= pid;
    @(posedge clk);
    mbap_proto_id = pid;
    cfg_index <= REG_UNIT_ID;
    cfg_data  <= {8'($urandom), uid};     // upper bits must be dropped
    @(posedge clk);
    mbap_unit_id = uid;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls, long holds on request, and the byte check
  // ---------------------------------------------------------------------------
  int rx_hold_left = 0;

  always @(posedge clk) begin : rx_side
    frame_byte_t due;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected output word: tx_byte %02h frame_last %0b rejected %0b",
               tx_byte, frame_last, rejected);
        mismatch_count++;
      end else begin
        due = frame_bytes_due.pop_front();
        if (tx_byte !== due.data) begin
          $error("tx_byte: expected %02h, got %02h", due.data, tx_byte);
          mismatch_count++;
        end
        if (frame_last !== due.last) begin
          $error("frame_last: expected %0b, got %0b", due.last, frame_last);
          mismatch_count++;
        end
        if (rejected !== due.rej) begin
          $error("rejected: expected %0b, got %0b", due.rej, rejected);
          mismatch_count++;
        end
      end
    end
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Runs under the reset config, so the header bytes also check the defaults
  task automatic test_directed_cases();
    int k;
    send_request(KIND_READ_HOLDING, 16'h0000, 16'h0001, 16'h0000);
    // large read count goes out unchecked
    send_request(KIND_READ_INPUT, 16'hffff, 16'hffff, 16'hffff);
    send_request(KIND_READ_HOLDING, 16'h1234, 16'h0000, 16'h5678);   // zero count
    send_request(KIND_READ_INPUT, 16'h8000, 16'h0000, 16'h0001);
    send_request(KIND_WRITE_SINGLE, 16'h1234, 16'hffff, 16'h0000);
    send_request(KIND_WRITE_SINGLE, 16'ha5a5, 16'h0000, 16'hffff);
    send_request(KIND_WRITE_MULTI, 16'h0100, 16'h0000, 16'h0000);    // zero count
    send_request(KIND_WRITE_MULTI, 16'h0100, 16'(MaxWriteWords + 1), 16'h0000);
    send_request(KIND_WRITE_MULTI, 16'h0100, 16'hffff, 16'hffff);
    send_request(KIND_DATA_WORD, 16'h0000, 16'h0000, 16'hbeef);      // stray word
    for (k = int'(KIND_DATA_WORD) + 1; k <= int'(KIND_TOP_CODE); k++) begin
      send_request(3'(k), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    // open frame: headers and bad kinds in the middle must not disturb it
    send_request(KIND_WRITE_MULTI, 16'h0000, 16'h0002, 16'h0000);
    send_request(KIND_READ_HOLDING, 16'h0001, 16'h0001, 16'h0000);
    send_request(KIND_WRITE_MULTI, 16'h0002, 16'h0001, 16'h0000);
    send_request(KIND_DATA_WORD, 16'hffff, 16'hffff, 16'h0000);
    send_request(KIND_TOP_CODE, 16'h0000, 16'h0000, 16'h0000);
    send_request(KIND_WRITE_SINGLE, 16'h0003, 16'h0000, 16'h1111);
    send_request(KIND_DATA_WORD, 16'h0000, 16'h0000, 16'hffff);      // closes frame
    send_request(KIND_WRITE_MULTI, 16'hffff, 16'h0001, 16'hffff);
    send_request(KIND_DATA_WORD, 16'h0000, 16'h0000, 16'h8001);
    wait_frames_drained();
  endtask

  // Mostly well-formed frames with random content, plus noise. While a
  // write-multiple frame is open most words are its data words.
  task automatic test_random_traffic(input int n_words);
    int i;
    int roll;
    logic [2:0]  k;
    logic [15:0] a;
    logic [15:0] c;
    logic [15:0] v;
    for (i = 0; i < n_words; i++) begin
      roll = $urandom_range(0, 99);
      a = 16'($urandom);
      c = 16'($urandom);
      v = 16'($urandom);
      if (owed_words != 7'd0) begin
        if (roll < 90) k = KIND_DATA_WORD;
        else k = 3'($urandom_range(int'(KIND_READ_HOLDING), int'(KIND_TOP_CODE)));
      end else if (roll < 35) begin
        k = KIND_WRITE_MULTI;
        // mostly short frames, now and then up to the largest
        if ($urandom_range(0, 19) == 0) c = 16'($urandom_range(1, MaxWriteWords));
        else c = 16'($urandom_range(1, 6));
      end else if (roll < 55) begin
        k = $urandom_range(0, 1) ? KIND_READ_HOLDING : KIND_READ_INPUT;
        if ($urandom_range(0, 9) == 0) c = 16'h0000;
      end else if (roll < 70) begin
        k = KIND_WRITE_SINGLE;
      end else if (roll < 80) begin
        k = KIND_WRITE_MULTI;                 // count out of range
        if ($urandom_range(0, 1)) c = 16'h0000;
        else c = 16'($urandom_range(MaxWriteWords + 1, 16'hffff));
      end else if (roll < 90) begin
        k = KIND_DATA_WORD;                   // stray
      end else begin
        k = 3'($urandom_range(int'(KIND_DATA_WORD) + 1, int'(KIND_TOP_CODE)));
      end
      send_request(k, a, c, v);
    end
    // close any open frame so the next phase starts clean
    while (owed_words != 7'd0) begin
      send_request(KIND_DATA_WORD, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    wait_frames_drained();
  endtask

  // Largest write-multiple frame while the receiver stalls for a long stretch;
  // the command queue fills and in_ready has to drop.
  task automatic test_output_backpressure();
    int i;
    rx_hold_req = LONG_HOLD_CYCLES;
    send_request(KIND_WRITE_MULTI, 16'($urandom), 16'(MaxWriteWords), 16'($urandom));
    for (i = 0; i < MaxWriteWords; i++) begin
      send_request(KIND_DATA_WORD, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    send_request(KIND_READ_INPUT, 16'($urandom), 16'($urandom_range(1, 16'hffff)),
                 16'($urandom));
    send_request(KIND_WRITE_SINGLE, 16'($urandom), 16'($urandom), 16'($urandom));
    wait_frames_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    tx_idle_pct = 7;
    rx_idle_pct = 51;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();

    set_mbap_config(16'hffff, 16'hffff, 8'hff);
    test_random_traffic(130);

    tx_idle_pct = 51;
    rx_idle_pct = 7;
    set_mbap_config(16'h0000, 16'h0000, 8'h00);
    test_random_traffic(130);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_mbap_config(16'($urandom), 16'($urandom), 8'($urandom));
    test_random_traffic(90);

    set_mbap_config(16'($urandom), 16'($urandom), 8'($urandom));
    test_output_backpressure();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

@@ modbus_tcp_request_framer_unit.f @@
hw/rtl/mbtrf_pkg.sv
hw/rtl/mbtrf_front.sv
hw/rtl/mbtrf_cmd_fifo.sv
hw/rtl/mbtrf_back.sv
hw/rtl/modbus_tcp_request_framer_unit.sv
hw/rtl/mbtrf_checker.sv
bench/tb_top.sv
